/* hw/rtl/iat_pkg.sv */
// Package for the adaptive threshold block: geometry constants, controller
// state codes and the command/status structs between controller and datapath.
// No dependencies.
package iat_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int AddrW      = ColW + RowW;
  localparam int Depth      = MaxWidth * MaxHeight;
  localparam int SumW       = 24;
  localparam int DivW       = ColW + RowW;
  localparam int DimW       = 9;

  localparam logic [2:0] RegWidth     = 3'd0;
  localparam logic [2:0] RegHeight    = 3'd1;
  localparam logic [2:0] RegHalfX     = 3'd2;
  localparam logic [2:0] RegHalfY     = 3'd3;
  localparam logic [2:0] RegThreshold = 3'd4;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_LDRD  = 11'b00000000010,
    ST_LDWR  = 11'b00000000100,
    ST_FRD0  = 11'b00000001000,
    ST_FRD1  = 11'b00000010000,
    ST_FRD2  = 11'b00000100000,
    ST_FRD3  = 11'b00001000000,
    ST_FSUM  = 11'b00010000000,
    ST_DGO   = 11'b00100000000,
    ST_DIV   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic       take_load;   // latch a load beat and advance raster
    logic       take_fetch;  // latch a fetch beat and window corners
    logic       ld_read;     // read integral above
    logic       ld_write;    // write pixel and integral
    logic [1:0] rd_sel;      // which corner to read
    logic       rd_en;
    logic       acc_en;      // accumulate corner read data
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic div_done;
  } status_t;

endpackage

/* hw/rtl/iat_ctrl.sv */
// Controller sequencing loads and fetches through the datapath.
// Depends on iat_pkg.
module iat_ctrl import iat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_func,
  output logic    in_stall,
  input  logic    out_busy,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            cmd.take_fetch = 1'b1;
            state_nxt = ST_FRD0;
          end else begin
            cmd.take_load = 1'b1;
            state_nxt = ST_LDRD;
          end
        end
      end
      ST_LDRD: begin
        cmd.ld_read = 1'b1;
        state_nxt = ST_LDWR;
      end
      ST_LDWR: begin
        cmd.ld_write = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FRD0: begin
        if (sts.outside) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = 2'd0;
          state_nxt = ST_FRD1;
        end
      end
      ST_FRD1: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd1;
        state_nxt = ST_FRD2;
      end
      ST_FRD2: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd2; cmd.acc_en = 1'b1;
        state_nxt = ST_FRD3;
      end
      ST_FRD3: begin
        cmd.rd_en = 1'b1; cmd.rd_sel = 2'd3; cmd.acc_en = 1'b1;
        state_nxt = ST_FSUM;
      end
      ST_FSUM: begin
        cmd.acc_en = 1'b1;
        state_nxt = ST_DGO;
      end
      ST_DGO: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/iat_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on iat_pkg.
module iat_div import iat_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SumW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output logic            done,
  output logic [SumW-1:0] quotient
);

  localparam int CntW = $clog2(SumW + 1);

  logic [SumW-1:0] q_r, q_nxt;
  logic [DivW:0]   rem_r, rem_nxt;
  logic [DivW-1:0] dsr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [DivW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = '0;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CntW'(SumW);
      busy_nxt = (divisor != '0);
      if (divisor == '0) q_nxt = '0;
    end else if (busy_r) begin
      trial = {rem_r[DivW-1:0], q_r[SumW-1]};
      q_nxt = {q_r[SumW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign done = !busy_r && !start;
  assign quotient = q_r;

endmodule

/* hw/rtl/iat_dp.sv */
// Datapath: pixel and integral memories, raster counters, window math,
// mean division and threshold compare. Depends on iat_pkg and iat_div.
module iat_dp import iat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           sts,
  input  logic [7:0]        in_pixel_value,
  input  logic [7:0]        in_pos_x,
  input  logic [7:0]        in_pos_y,
  input  logic [DimW-1:0]   cfg_w,
  input  logic [DimW-1:0]   cfg_h,
  input  logic [6:0]        cfg_hx,
  input  logic [6:0]        cfg_hy,
  input  logic signed [8:0] cfg_thr,
  output logic              bin_nxt
);

  logic [7:0]      pix_mem [Depth];
  logic [SumW-1:0] int_mem [Depth];

  logic [DimW-1:0] w_sat, h_sat;
  always_comb begin
    w_sat = (cfg_w < DimW'(2)) ? DimW'(2) :
            (cfg_w > DimW'(MaxWidth)) ? DimW'(MaxWidth) : cfg_w;
    h_sat = (cfg_h < DimW'(2)) ? DimW'(2) :
            (cfg_h > DimW'(MaxHeight)) ? DimW'(MaxHeight) : cfg_h;
  end

  // raster state
  logic [DimW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [SumW-1:0] rsum_r, rsum_nxt;
  logic [ColW-1:0] lc_r;
  logic [RowW-1:0] lr_r;
  logic [7:0]      lpix_r;
  logic            has_above_r;
  logic [ColW-1:0] lc_nxt_w;
  logic [RowW-1:0] lr_nxt_w;
  logic [SumW-1:0] lsum_nxt_w, lsum_r;

  always_comb begin
    logic [DimW-1:0] c, r;
    logic [SumW-1:0] s;
    c = col_r; r = row_r; s = rsum_r;
    if (c >= w_sat) begin
      c = '0; r = r + 1'b1; s = '0;
    end
    if (r >= h_sat) begin
      r = '0; s = '0;
    end
    if (c == '0) s = '0;
    s = s + SumW'(in_pixel_value);
    col_nxt = c + 1'b1;
    row_nxt = r;
    rsum_nxt = s;
    if (col_nxt >= w_sat) begin
      col_nxt = '0; rsum_nxt = '0; row_nxt = r + 1'b1;
      if (row_nxt >= h_sat) row_nxt = '0;
    end
    lc_nxt_w = c[ColW-1:0];
    lr_nxt_w = r[RowW-1:0];
    lsum_nxt_w = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; rsum_r <= '0;
    end else if (cmd.take_load) begin
      col_r <= col_nxt; row_r <= row_nxt; rsum_r <= rsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      lc_r <= lc_nxt_w; lr_r <= lr_nxt_w; lsum_r <= lsum_nxt_w;
      lpix_r <= in_pixel_value; has_above_r <= (lr_nxt_w != '0);
    end
  end

  // fetch window
  logic [ColW-1:0] bx_r, ex_r, px_r;
  logic [RowW-1:0] by_r, ey_r, py_r;
  logic            outside_r;
  logic [8:0]      ex_t, ey_t;
  always_comb begin
    ex_t = 9'(in_pos_x) + 9'(cfg_hx);
    if (ex_t > w_sat - 1'b1) ex_t = w_sat - 1'b1;
    ey_t = 9'(in_pos_y) + 9'(cfg_hy);
    if (ey_t > h_sat - 1'b1) ey_t = h_sat - 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.take_fetch) begin
      outside_r <= (9'(in_pos_x) >= w_sat) || (9'(in_pos_y) >= h_sat);
      bx_r <= (in_pos_x > 8'(cfg_hx)) ? in_pos_x - 8'(cfg_hx) : '0;
      by_r <= (in_pos_y > 8'(cfg_hy)) ? in_pos_y - 8'(cfg_hy) : '0;
      ex_r <= ex_t[ColW-1:0];
      ey_r <= ey_t[RowW-1:0];
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
  end

  // memory ports
  logic [AddrW-1:0] raddr;
  logic [SumW-1:0]  rdata_r;
  logic [7:0]       pdata_r;
  logic [1:0]       sel_d_r;
  always_comb begin
    unique case (cmd.rd_sel)
      2'd0: raddr = {ey_r, ex_r};
      2'd1: raddr = {by_r, bx_r};
      2'd2: raddr = {ey_r, bx_r};
      2'd3: raddr = {by_r, ex_r};
      default: raddr = '0;
    endcase
    if (cmd.ld_read) raddr = {lr_r - 1'b1, lc_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en || cmd.ld_read) rdata_r <= int_mem[raddr];
    if (cmd.ld_write) begin
      int_mem[{lr_r, lc_r}] <= lsum_r + (has_above_r ? rdata_r : '0);
      pix_mem[{lr_r, lc_r}] <= lpix_r;
    end
    if (cmd.rd_en) pdata_r <= pix_mem[{py_r, px_r}];
    sel_d_r <= cmd.rd_sel;
  end

  // corner accumulation (data arrives the cycle after its read)
  logic [SumW-1:0] acc_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_en && cmd.rd_sel == 2'd1) begin
      acc_r <= rdata_r;
    end else if (cmd.acc_en) begin
      if (sel_d_r == 2'd1) acc_r <= acc_r + rdata_r;
      else acc_r <= acc_r - rdata_r;
    end
  end

  // divisor product
  logic [DivW-1:0] div_r;
  always_ff @(posedge clk) begin
    div_r <= DivW'(ex_r - bx_r) * DivW'(ey_r - by_r);
  end

  logic [SumW-1:0] mean;
  logic            div_done;
  iat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (div_r),
    .done     (div_done),
    .quotient (mean)
  );

  assign sts = '{outside: outside_r, div_done: div_done};

  logic signed [SumW+1:0] diff;
  always_comb begin
    diff = $signed({2'b00, SumW'(pdata_r)}) - $signed({2'b00, mean});
    bin_nxt = !outside_r && (diff > (SumW+2)'(cfg_thr));
  end

endmodule

/* hw/rtl/integral_image_adaptive_threshold.sv */
// Adaptive binary threshold against a local mean taken from an integral image.
// Depends on iat_pkg, iat_ctrl, iat_dp.
//
// Input channel: in_valid/in_stall with in_func, in_pixel_value, in_pos_x,
// in_pos_y. A load beat (func 0) stores the next raster pixel and its
// integral entry; its steps are accept, read row above, write.
// A fetch beat (func 1) reads four integral corners over one memory port
// and the pixel from the pixel memory, then divides the window sum by the
// window area in a bit-serial divider of 24 steps, which a zero half
// window skips. An outside fetch answers 0.
// One item is in work at a time; in_stall is high while it is.
// Output channel: out_valid/out_stall with out_bin_value, held in an
// output register. The next item is accepted while that register still
// waits; a second result waits in the controller until the register is
// free, so a stalled receiver holds everything without loss.
// Configuration: APB-style, registers at 4*i; the user must write them only
// when idle, and the block itself does not enforce it. Reset (rst_n low,
// synchronous) clears raster position, running sum, control state and
// registers to their defaults. Memory contents are undefined until loaded; no clearing pass is run.
module integral_image_adaptive_threshold import iat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_pixel_value,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_bin_value,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [DimW-1:0]   w_r, h_r;
  logic [6:0]        hx_r, hy_r;
  logic signed [8:0] thr_r;
  logic [2:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[4:2];

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= DimW'(256); h_r <= DimW'(256);
      hx_r <= 7'd15; hy_r <= 7'd15; thr_r <= 9'sd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        RegWidth:     w_r   <= cfg_pwdata[8:0];
        RegHeight:    h_r   <= cfg_pwdata[8:0];
        RegHalfX:     hx_r  <= cfg_pwdata[6:0];
        RegHalfY:     hy_r  <= cfg_pwdata[6:0];
        RegThreshold: thr_r <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      RegWidth:     cfg_prdata = 32'(w_r);
      RegHeight:    cfg_prdata = 32'(h_r);
      RegHalfX:     cfg_prdata = 32'(hx_r);
      RegHalfY:     cfg_prdata = 32'(hy_r);
      RegThreshold: cfg_prdata = 32'(thr_r[8:0]);
      default:      cfg_prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t sts;
  logic    bin_nxt;
  logic    out_busy;

  // output register frees when the receiver takes the beat
  assign out_busy = out_valid && out_stall;

  iat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  iat_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel_value (in_pixel_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .cfg_w          (w_r),
    .cfg_h          (h_r),
    .cfg_hx         (hx_r),
    .cfg_hy         (hy_r),
    .cfg_thr        (thr_r),
    .bin_nxt        (bin_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_bin_value <= bin_nxt;
  end

endmodule

/* hw/rtl/iat_checker.sv */
// Port-level checker for the adaptive threshold block, with its bind.
// Depends on integral_image_adaptive_threshold ports only.
module iat_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_func,
  input logic out_valid,
  input logic out_stall,
  input logic out_bin_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_value))
    else $error("stalled result changed");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_func |=> !($rose(out_valid)))
    else $error("load produced a result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second item at once");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integral_image_adaptive_threshold iat_checker u_iat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_bin_value (out_bin_value)
);
